### sv/lpnd_pkg.sv
// Package for the linear probe name directory: widths, commands, status codes
// and the controller state type. No dependencies.
`timescale 1ns / 1ps
package lpnd_pkg;
    localparam int TableDepth   = 1024;
    localparam int SlotBits     = $clog2(TableDepth);
    localparam int SizeBits     = SlotBits + 1;
    localparam int KeyBits      = 64;
    localparam int LenBits      = 4;
    localparam int PosBits      = 16;
    localparam int HashBits     = 32;
    localparam int EntryBits    = KeyBits + LenBits + 1 + PosBits;
    localparam logic [LenBits-1:0] MaxKeyBytes = 4'd8;

    typedef logic [1:0] cmd_t;
    localparam cmd_t CmdInsert     = 2'd0;
    localparam cmd_t CmdLookPlace  = 2'd1;
    localparam cmd_t CmdLookTrans  = 2'd2;
    localparam cmd_t CmdLookAny    = 2'd3;

    typedef logic [1:0] status_t;
    localparam status_t StOk        = 2'd0;
    localparam status_t StNotFound  = 2'd1;
    localparam status_t StWrongKind = 2'd2;
    localparam status_t StFull      = 2'd3;

    typedef struct packed {
        logic [KeyBits-1:0] key;
        logic [LenBits-1:0] len;
        logic               kind;
        logic [PosBits-1:0] pos;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_HASH, S_MOD, S_READ, S_CHECK, S_DONE
    } state_t;

    // Write request from controller to slot memory.
    typedef struct packed {
        logic                en;
        logic [SlotBits-1:0] addr;
        entry_t              data;
    } mem_wr_t;
endpackage

### sv/lpnd_slot_ram.sv
// Slot store of the name directory: one write port, one read port,
// registered read data. Uses lpnd_pkg.
`timescale 1ns / 1ps
module lpnd_slot_ram (
    input  logic                    aclk,
    input  lpnd_pkg::mem_wr_t       wr,
    input  logic [lpnd_pkg::SlotBits-1:0] rd_addr,
    output lpnd_pkg::entry_t        rd_data
);
    import lpnd_pkg::*;
    entry_t mem [TableDepth];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

### sv/lpnd_ctrl.sv
// Controller of the name directory: clearing of the slots after reset, hashing,
// iterative modulo, probe walk over the slot memory and result formation. Uses lpnd_pkg.
`timescale 1ns / 1ps
module lpnd_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [lpnd_pkg::SizeBits-1:0] table_size,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  lpnd_pkg::cmd_t                in_cmd,
    input  logic [lpnd_pkg::KeyBits-1:0]  in_key,
    input  logic [lpnd_pkg::LenBits-1:0]  in_len,
    input  logic                          in_kind,
    input  logic [lpnd_pkg::PosBits-1:0]  in_pos,
    output logic                          res_valid,
    input  logic                          res_ready,
    output logic [60:0]                   res_data,
    output lpnd_pkg::mem_wr_t             wr,
    output logic [lpnd_pkg::SlotBits-1:0] rd_addr,
    input  lpnd_pkg::entry_t              rd_data
);
    import lpnd_pkg::*;

    state_t state_reg, state_next;
    cmd_t                cmd_reg;
    logic [KeyBits-1:0]  key_reg;
    logic [LenBits-1:0]  len_reg;
    logic                kind_reg;
    logic [PosBits-1:0]  pos_reg;
    logic [HashBits-1:0] hash_reg, hash_next;
    logic [LenBits-1:0]  cnt_reg;
    logic [5:0]          mbit_reg;
    logic [SlotBits:0]   rem_reg;
    logic [SlotBits:0]   n_reg;
    logic [SlotBits-1:0] idx_reg, start_reg, clr_reg;
    logic [31:0]         conf_reg;
    logic                out_valid_reg;
    logic [60:0]         out_reg, out_next;
    logic [SlotBits-1:0] idx_inc;
    logic                wrap;
    logic [SlotBits+1:0] rem_sh;
    logic                match;
    logic [LenBits-1:0]  len_c;
    logic [KeyBits-1:0]  kmask;
    logic [7:0]          ch;

    // Key normalization of the accepted beat.
    always_comb begin
        len_c = (in_len > MaxKeyBytes) ? MaxKeyBytes : in_len;
        kmask = '0;
        for (int b = 0; b < 8; b++) begin
            if (LenBits'(b) < len_c) kmask[b*8 +: 8] = 8'hFF;
        end
    end

    always_comb begin
        ch = key_reg[cnt_reg[2:0]*8 +: 8];
        hash_next = hash_reg * 32'd31 + {{24{ch[7]}}, ch};
    end

    // The divider consumes the hash from bit 31 down to bit 0.
    assign rem_sh = {rem_reg, hash_reg[mbit_reg[4:0] - 5'd1]};
    assign idx_inc = idx_reg + 1'b1;
    assign wrap = ({1'b0, idx_inc} == n_reg) ? 1'b1 : 1'b0;
    assign match = (rd_data.len == len_reg) && (rd_data.key == key_reg);
    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign res_valid = out_valid_reg;
    assign res_data = out_reg;

    logic [SlotBits-1:0] nxt_idx;
    assign nxt_idx = wrap ? '0 : idx_inc;
    logic last_probe;
    assign last_probe = (nxt_idx == start_reg);

    always_comb begin
        unique case (state_reg)
            S_CLEAR: rd_addr = clr_reg;
            S_READ:  rd_addr = idx_reg;
            default: rd_addr = idx_reg;
        endcase
    end

    always_comb begin
        wr = '0;
        if (state_reg == S_CLEAR) begin
            wr.en = 1'b1;
            wr.addr = clr_reg;
        end else if (state_reg == S_CHECK && cmd_reg == CmdInsert
                     && rd_data.len == '0) begin
            wr.en = 1'b1;
            wr.addr = idx_reg;
            wr.data.key = key_reg;
            wr.data.len = len_reg;
            wr.data.kind = kind_reg;
            wr.data.pos = pos_reg;
        end
    end

    // Result fields formed from the slot being checked.
    always_comb begin
        out_next = '0;
        if (cmd_reg == CmdInsert) begin
            if (rd_data.len == '0) begin
                out_next[1:0] = StOk;
                out_next[11:2] = idx_reg;
            end else if (last_probe) out_next[1:0] = StFull;
        end else if (match) begin
            out_next[11:2] = idx_reg;
            out_next[28] = rd_data.kind;
            if ((cmd_reg == CmdLookPlace && !rd_data.kind) ||
                (cmd_reg == CmdLookTrans && rd_data.kind))
                out_next[1:0] = StWrongKind;
            else begin
                out_next[1:0] = StOk;
                out_next[27:12] = rd_data.pos;
            end
        end else if (last_probe) out_next[1:0] = StNotFound;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (&clr_reg) state_next = S_IDLE;
            S_IDLE:  if (in_valid && in_ready) state_next = S_HASH;
            S_HASH:  if (cnt_reg == len_reg) state_next = S_MOD;
            S_MOD:   if (mbit_reg == 6'd0) state_next = S_READ;
            S_READ:  state_next = S_CHECK;
            S_CHECK: begin
                if (cmd_reg == CmdInsert) begin
                    if (rd_data.len == '0 || last_probe) state_next = S_DONE;
                    else state_next = S_READ;
                end else begin
                    if (match || last_probe) state_next = S_DONE;
                    else state_next = S_READ;
                end
            end
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            conf_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (out_valid_reg && res_ready) out_valid_reg <= 1'b0;
            if (state_reg == S_CHECK && cmd_reg == CmdInsert
                && rd_data.len != '0) conf_reg <= conf_reg + 1'b1 - {31'd0, last_probe};
            if (state_reg == S_DONE) out_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                cmd_reg <= in_cmd;
                key_reg <= in_key & kmask;
                len_reg <= len_c;
                kind_reg <= in_kind;
                pos_reg <= in_pos;
                hash_reg <= '0;
                cnt_reg <= '0;
                if (table_size == '0) n_reg <= (SlotBits+1)'(1);
                else if (table_size > SizeBits'(TableDepth))
                    n_reg <= (SlotBits+1)'(TableDepth);
                else n_reg <= table_size[SlotBits:0];
            end
            S_HASH: begin
                if (cnt_reg == len_reg) hash_reg <= hash_reg * 32'd31;
                else begin
                    hash_reg <= hash_next;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                mbit_reg <= 6'd32;
                rem_reg <= '0;
            end
            S_MOD: begin
                // Restoring division, one quotient bit per cycle.
                if (mbit_reg != 6'd0) begin
                    mbit_reg <= mbit_reg - 1'b1;
                    if (rem_sh >= {1'b0, n_reg}) rem_reg <= (SlotBits+1)'(rem_sh - {1'b0, n_reg});
                    else rem_reg <= rem_sh[SlotBits:0];
                end else begin
                    idx_reg <= rem_reg[SlotBits-1:0];
                    start_reg <= rem_reg[SlotBits-1:0];
                end
            end
            S_CHECK: begin
                if (state_next == S_READ) idx_reg <= nxt_idx;
                out_reg <= out_next;
            end
            S_DONE: out_reg[60:29] <= conf_reg;
            default: ;
        endcase
    end
endmodule

### sv/linear_probe_name_directory.sv
// Top level of the linear probe name directory: configuration register,
// controller and slot memory. Uses lpnd_pkg, lpnd_ctrl, lpnd_slot_ram.
`timescale 1ns / 1ps
// Usage: each beat on the s_ channel is one command (insert or one of three
// lookups) carrying a name of up to eight bytes. Exactly one result beat
// leaves on the m_ channel per command, in order.
// The name is hashed one character per cycle, reduced modulo the table size
// by a restoring divider, and the slot memory is then probed slot by slot
// around the ring. The registered read of the slot memory, followed by the
// compare, sets the probe rate.
// After reset the block clears all 1024 slots, one per cycle, and holds
// s_axis_tready low while it clears them; table_size resets to 1024.
// table_size may be written through cfg_wr_en only while the block is idle.
// A result waits in its output register while m_axis_tready is low; no
// new command is taken until it has left.
module linear_probe_name_directory (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,  // table_size
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // key_bytes[63:0], key_length[67:64], is_place[68], position[84:69]
    input  logic [87:0] s_axis_tdata,
    // command[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], slot[11:2], found_position[27:12], found_is_place[28],
    // conflicts[60:29]
    output logic [63:0] m_axis_tdata
);
    import lpnd_pkg::*;

    logic [SizeBits-1:0] size_reg;
    mem_wr_t             wr;
    logic [SlotBits-1:0] rd_addr;
    entry_t              rd_data;
    logic [60:0]         res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= SizeBits'(TableDepth);
        end else if (cfg_wr_en) begin
            size_reg <= cfg_wr_data;
        end
    end

    lpnd_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .table_size(size_reg),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_cmd(s_axis_tuser), .in_key(s_axis_tdata[63:0]),
        .in_len(s_axis_tdata[67:64]), .in_kind(s_axis_tdata[68]),
        .in_pos(s_axis_tdata[84:69]),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_data(res),
        .wr(wr), .rd_addr(rd_addr), .rd_data(rd_data)
    );

    lpnd_slot_ram u_ram (.aclk(aclk), .wr(wr), .rd_addr(rd_addr), .rd_data(rd_data));

    assign m_axis_tdata = {3'b000, res};
endmodule
